>>> rtl/core/substring_of_another_word_counter_macros.svh
// Assertion macros shared by the checker files of the substring counter.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef SUBSTRING_OF_ANOTHER_WORD_COUNTER_MACROS_SVH
`define SUBSTRING_OF_ANOTHER_WORD_COUNTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SOWC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sowc assertion failed");

// Next-cycle implication, disabled during reset.
`define SOWC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sowc assertion failed");

`endif

>>> rtl/core/sowc_pkg.sv
// Package of the substring counter: sizes, data types and the command and
// status structs between controller and datapath. Depends on nothing.
package sowc_pkg;

   localparam int MAX_WORDS   = 1024;
   localparam int MAX_LEN     = 128;
   localparam int CHAR_W      = 8;
   localparam int COUNT_W     = 11;
   localparam int WORD_W      = $clog2(MAX_WORDS);
   localparam int POS_W       = $clog2(MAX_LEN);
   localparam int TOTAL_W     = $clog2(MAX_WORDS + 1);
   localparam int LEN_W       = $clog2(MAX_LEN + 1);
   localparam int STORE_DEPTH = MAX_WORDS * (2 ** POS_W);
   localparam int COUNT_MAX   = (2 ** COUNT_W) - 1;

   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_en;
      logic a_clear;
      logic a_inc;
      logic len_rd_a;
      logic len_rd_b;
      logic nl_latch;
      logic hl_latch;
      logic b_clear;
      logic b_inc;
      logic start_clear;
      logic start_inc;
      logic pos_clear;
      logic pos_inc;
      logic mem_rd;
      logic count_clear;
      logic count_inc;
      logic result_load;
      logic set_clear;
   } sowc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic a_done;
      logic b_done;
      logic b_is_a;
      logic nl_gt_hl;
      logic window_over;
      logic char_eq;
      logic last_pos;
   } sowc_status_type;

endpackage

>>> rtl/core/sowc_if.sv
// Channel interfaces of the substring counter: the character input and the
// count result. Depends on sowc_pkg.
interface sowc_req_if;
   import sowc_pkg::*;

   logic     valid;
   logic     ready;
   char_type character;
   logic     word_end;
   logic     set_end;

   modport source (output valid, output character, output word_end, output set_end,
                   input ready);
   modport sink (input valid, input character, input word_end, input set_end,
                 output ready);
endinterface

interface sowc_rsp_if;
   import sowc_pkg::*;

   logic      valid;
   logic      ready;
   count_type match_count;

   modport source (output valid, output match_count, input ready);
   modport sink (input valid, input match_count, output ready);
endinterface

>>> rtl/core/sowc_datapath.sv
// Datapath of the substring counter: word and length memories, loop counters,
// comparator and result register. Depends on sowc_pkg.
module sowc_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  sowc_pkg::char_type       in_character,
   input  logic                     in_word_end,
   input  logic                     in_set_end,
   input  sowc_pkg::sowc_cmd_type   cmd,
   output sowc_pkg::sowc_status_type status,
   output sowc_pkg::count_type      match_count
);
   import sowc_pkg::*;

   logic [CHAR_W-1:0] store_mem [STORE_DEPTH];
   logic [LEN_W-1:0]  len_mem [MAX_WORDS];

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] result_ff;
   logic [TOTAL_W-1:0] a_ff, b_ff;
   logic [LEN_W-1:0]   start_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [LEN_W-1:0]   nl_ff, hl_ff;
   logic [LEN_W-1:0]   len_rdata_ff;
   logic [CHAR_W-1:0]  n_data_ff, h_data_ff;

   logic                       store_en, word_close, len_wr;
   logic [LEN_W-1:0]           fill_after;
   logic [WORD_W+POS_W-1:0]    wr_addr, n_addr, h_addr;
   logic [LEN_W-1:0]           h_pos;
   logic [WORD_W-1:0]          len_rd_addr;
   logic [LEN_W:0]             window_end;

   assign store_en   = cmd.load_en && (total_ff < TOTAL_W'(MAX_WORDS))
                       && (fill_ff < LEN_W'(MAX_LEN));
   assign word_close = cmd.load_en && (in_word_end || in_set_end);
   assign fill_after = fill_ff + LEN_W'(store_en);
   assign len_wr     = word_close && (total_ff < TOTAL_W'(MAX_WORDS))
                       && (fill_after != '0);
   assign wr_addr    = {total_ff[WORD_W-1:0], fill_ff[POS_W-1:0]};
   assign h_pos      = start_ff + LEN_W'(pos_ff);
   assign n_addr     = {a_ff[WORD_W-1:0], pos_ff};
   assign h_addr     = {b_ff[WORD_W-1:0], h_pos[POS_W-1:0]};
   assign len_rd_addr = cmd.len_rd_b ? b_ff[WORD_W-1:0] : a_ff[WORD_W-1:0];
   assign window_end = {1'b0, start_ff} + {1'b0, nl_ff};

   always_comb begin
      fill_in = fill_ff;
      if (word_close) begin
         fill_in = '0;
      end else if (store_en) begin
         fill_in = fill_after;
      end

      total_in = total_ff;
      if (cmd.set_clear) begin
         total_in = '0;
      end else if (len_wr) begin
         total_in = total_ff + TOTAL_W'(1);
      end

      count_in = count_ff;
      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.count_inc && (count_ff != COUNT_W'(COUNT_MAX))) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         total_ff <= total_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   // Word store: one write port for loading, two registered read ports.
   always_ff @(posedge clock) begin
      if (store_en) begin
         store_mem[wr_addr] <= in_character;
      end
      if (cmd.mem_rd) begin
         n_data_ff <= store_mem[n_addr];
         h_data_ff <= store_mem[h_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_wr) begin
         len_mem[total_ff[WORD_W-1:0]] <= fill_after;
      end
      if (cmd.len_rd_a || cmd.len_rd_b) begin
         len_rdata_ff <= len_mem[len_rd_addr];
      end
   end

   // Loop counters and latched lengths.
   always_ff @(posedge clock) begin
      if (cmd.a_clear) begin
         a_ff <= '0;
      end else if (cmd.a_inc) begin
         a_ff <= a_ff + TOTAL_W'(1);
      end
      if (cmd.b_clear) begin
         b_ff <= '0;
      end else if (cmd.b_inc) begin
         b_ff <= b_ff + TOTAL_W'(1);
      end
      if (cmd.start_clear) begin
         start_ff <= '0;
      end else if (cmd.start_inc) begin
         start_ff <= start_ff + LEN_W'(1);
      end
      if (cmd.pos_clear) begin
         pos_ff <= '0;
      end else if (cmd.pos_inc) begin
         pos_ff <= pos_ff + POS_W'(1);
      end
      if (cmd.nl_latch) begin
         nl_ff <= len_rdata_ff;
      end
      if (cmd.hl_latch) begin
         hl_ff <= len_rdata_ff;
      end
      if (cmd.result_load) begin
         result_ff <= count_ff;
      end
   end

   assign status.a_done      = (a_ff == total_ff);
   assign status.b_done      = (b_ff == total_ff);
   assign status.b_is_a      = (b_ff == a_ff);
   assign status.nl_gt_hl    = (nl_ff > hl_ff);
   assign status.window_over = (window_end > {1'b0, hl_ff});
   assign status.char_eq     = (n_data_ff == h_data_ff);
   assign status.last_pos    = ((LEN_W'(pos_ff) + LEN_W'(1)) == nl_ff);

   assign match_count = result_ff;

endmodule

>>> rtl/core/sowc_ctrl.sv
// Controller of the substring counter: sequences loading, the pairwise
// brute-force search and the result handshake. Depends on sowc_pkg.
module sowc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_set_end,
   input  logic                      rsp_ready,
   input  sowc_pkg::sowc_status_type status,
   output sowc_pkg::sowc_cmd_type    cmd,
   output logic                      req_ready,
   output logic                      rsp_valid
);
   import sowc_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_A_START,
      ST_A_LEN,
      ST_B_START,
      ST_B_LEN,
      ST_B_CHECK,
      ST_WINDOW,
      ST_P_READ,
      ST_P_CMP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, slot_free;

   assign req_ready = (state_ff == ST_LOAD);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.load_en  = accept;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_set_end) begin
               cmd.count_clear = 1'b1;
               cmd.a_clear     = 1'b1;
               state_in        = ST_A_START;
            end
         end
         ST_A_START: begin
            if (status.a_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.len_rd_a = 1'b1;
               state_in     = ST_A_LEN;
            end
         end
         ST_A_LEN: begin
            cmd.nl_latch = 1'b1;
            cmd.b_clear  = 1'b1;
            state_in     = ST_B_START;
         end
         ST_B_START: begin
            if (status.b_done) begin
               cmd.a_inc = 1'b1;
               state_in  = ST_A_START;
            end else if (status.b_is_a) begin
               cmd.b_inc = 1'b1;
            end else begin
               cmd.len_rd_b = 1'b1;
               state_in     = ST_B_LEN;
            end
         end
         ST_B_LEN: begin
            cmd.hl_latch = 1'b1;
            state_in     = ST_B_CHECK;
         end
         ST_B_CHECK: begin
            if (status.nl_gt_hl) begin
               cmd.b_inc = 1'b1;
               state_in  = ST_B_START;
            end else begin
               cmd.start_clear = 1'b1;
               state_in        = ST_WINDOW;
            end
         end
         ST_WINDOW: begin
            if (status.window_over) begin
               cmd.b_inc = 1'b1;
               state_in  = ST_B_START;
            end else begin
               cmd.pos_clear = 1'b1;
               state_in      = ST_P_READ;
            end
         end
         ST_P_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_P_CMP;
         end
         ST_P_CMP: begin
            if (!status.char_eq) begin
               cmd.start_inc = 1'b1;
               state_in      = ST_WINDOW;
            end else if (status.last_pos) begin
               // Found inside one other word; move on to the next candidate.
               cmd.count_inc = 1'b1;
               cmd.a_inc     = 1'b1;
               state_in      = ST_A_START;
            end else begin
               cmd.pos_inc = 1'b1;
               state_in    = ST_P_READ;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.result_load = 1'b1;
               cmd.set_clear   = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/substring_of_another_word_counter.sv
// Top level of the substring counter: joins controller and datapath to the
// request and response channels. Depends on sowc_pkg, sowc_if, sowc_ctrl, sowc_datapath.
//
//   Channel   Direction  Payload                           Transaction
//   req_chan  in         character, word_end, set_end      one character of a word
//   rsp_chan  out        match_count                       one count per word set
//
// Loading takes one character per cycle while no search is running; a transaction with
// set_end closes the set. The search then walks ordered pairs of distinct words and moves
// on to the next word at its first match. Fetching a word's length takes a read state and
// a latch state, each pair then passes B_START, B_LEN and B_CHECK, each start position one
// window check, and each character compare a read state, then a compare state. The worst
// case is a needle about half as long as its haystack that fails on its last character at every start.
// A response stalled by rsp_chan.ready does not block loading of the next set, but
// that set's count then waits in the finish state, with the input stalled, until the
// response slot frees.
// Reset is synchronous and active high; the memories need no clearing pass.
module substring_of_another_word_counter (
   input logic        clock,
   input logic        reset,
   sowc_req_if.sink   req_chan,
   sowc_rsp_if.source rsp_chan
);
   import sowc_pkg::*;

   sowc_cmd_type    cmd;
   sowc_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   count_type       match_count;

   // The controller owns the handshakes and walks the search loops.
   sowc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_set_end (req_chan.set_end),
      .rsp_ready   (rsp_chan.ready),
      .status      (status),
      .cmd         (cmd),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid)
   );

   // The datapath stores the words and performs the compares.
   sowc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .in_character (req_chan.character),
      .in_word_end  (req_chan.word_end),
      .in_set_end   (req_chan.set_end),
      .cmd          (cmd),
      .status       (status),
      .match_count  (match_count)
   );

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.match_count = match_count;

endmodule

>>> rtl/core/sowc_checker.sv
// Port-level checker of the substring counter and its bind to the top level.
// Depends on sowc_pkg and the macros header.
`include "substring_of_another_word_counter_macros.svh"

module sowc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_set_end,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input sowc_pkg::count_type rsp_match_count
);
   import sowc_pkg::*;

   `SOWC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `SOWC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_match_count))

   `SOWC_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, rsp_match_count <= COUNT_W'(MAX_WORDS))

   `SOWC_ASSERT_NEXT(a_search_blocks, clock, reset, req_valid && req_ready && req_set_end, !req_ready)

endmodule

bind substring_of_another_word_counter sowc_checker u_sowc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_set_end     (req_chan.set_end),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_match_count (rsp_chan.match_count)
);

>>> verif/sowc_count_checker.sv
`timescale 1ns / 100ps
// Checker for the substring counter: watches the character and count channels,
// predicts each count from the accepted characters and compares. Depends on sowc_pkg, sowc_if.
module sowc_count_checker (
   input  logic clock,
   input  logic reset,
   sowc_req_if  req_mon,
   sowc_rsp_if  rsp_mon,
   output int   error_total,
   output int   counts_pending,
   output int   counts_checked
);
   import sowc_pkg::*;

   localparam int REPORT_LIMIT = 10;

   char_type  word_text [MAX_WORDS][MAX_LEN];
   int        word_len [MAX_WORDS];
   int        words_held = 0;
   int        fill_at = 0;
   int        errors = 0;
   int        checked = 0;
   count_type expected_counts [$];

   // True when word needle appears somewhere inside word hay.
   function automatic bit occurs_within(input int needle, input int hay);
      int nl;
      int hl;
      bit hit;
      nl = word_len[needle];
      hl = word_len[hay];
      if (nl > hl) return 1'b0;
      for (int s = 0; s + nl <= hl; s++) begin
         hit = 1'b1;
         for (int p = 0; p < nl; p++) begin
            if (word_text[needle][p] != word_text[hay][s + p]) begin
               hit = 1'b0;
               break;
            end
         end
         if (hit) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Each word counts once, at the first other word that contains it.
   function automatic count_type count_contained_words();
      int found;
      found = 0;
      for (int a = 0; a < words_held; a++) begin
         for (int b = 0; b < words_held; b++) begin
            if (a != b && occurs_within(a, b)) begin
               if (found < COUNT_MAX) found++;
               break;
            end
         end
      end
      return count_type'(found);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         words_held = 0;
         fill_at = 0;
         expected_counts.delete();
      end else begin
         // Results are handled first, so a count can never match a set closed
         // at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_counts.size() == 0) begin
               if (errors < REPORT_LIMIT)
                  $display("unexpected count %0d with no word set pending",
                           rsp_mon.match_count);
               errors++;
            end else begin
               if (rsp_mon.match_count !== expected_counts[0]) begin
                  if (errors < REPORT_LIMIT)
                     $display("match_count mismatch: expected %0d, got %0d",
                              expected_counts[0], rsp_mon.match_count);
                  errors++;
               end
               void'(expected_counts.pop_front());
               checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (words_held < MAX_WORDS && fill_at < MAX_LEN) begin
               word_text[words_held][fill_at] = req_mon.character;
               fill_at++;
            end
            if (req_mon.word_end || req_mon.set_end) begin
               if (words_held < MAX_WORDS && fill_at > 0) begin
                  word_len[words_held] = fill_at;
                  words_held++;
               end
               fill_at = 0;
            end
            if (req_mon.set_end) begin
               expected_counts.push_back(count_contained_words());
               words_held = 0;
               fill_at = 0;
            end
         end
      end
      error_total    <= errors;
      counts_pending <= expected_counts.size();
      counts_checked <= checked;
   end

endmodule

>>> verif/tb_substring_of_another_word_counter.sv
`timescale 1ns / 100ps
// Top of the substring counter testbench: clock, reset, stimulus and verdict.
// Depends on sowc_pkg, sowc_if, sowc_count_checker and the counter itself.
module tb_substring_of_another_word_counter;
   import sowc_pkg::*;

   // The longest quiet stretch of a correct run is the receiver hold-off or the
   // search of the largest set sent here; the limit sits far above both.
   localparam int QUIET_LIMIT   = 500_000;
   localparam int HOLD_CYCLES   = 1500;
   localparam int DRAIN_CYCLES  = 500;
   localparam int RANDOM_ITEMS  = 650;
   localparam int LONG_WORD_LEN = MAX_LEN + 4;

   logic clock = 1'b0;
   logic reset;

   sowc_req_if req_chan ();
   sowc_rsp_if rsp_chan ();

   int error_total;
   int counts_pending;
   int counts_checked;

   // Shared between the sender and the receiver: steady turns random idling off
   // on both sides, and hold_arm asks the receiver for one long hold-off.
   bit steady;
   bit hold_arm;

   int chars_sent = 0;
   int sets_sent = 0;

   // Scratch word being sent, and the words already sent in the current set, kept
   // flat so that later words can be built from earlier ones.
   char_type word_buf [$];
   char_type hist_text [$];
   int       hist_off [$];
   int       hist_len [$];

   always #6 clock = ~clock;

   substring_of_another_word_counter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   sowc_count_checker checker_0 (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .error_total    (error_total),
      .counts_pending (counts_pending),
      .counts_checked (counts_checked)
   );

   // Receiver. Ready changes only at the falling edge. When the sender arms a
   // hold-off, ready stays low while a counter loaded from HOLD_CYCLES runs down, so that the
   // finished count backs up, the next set loads behind it and the input stalls.
   initial begin : count_sink
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_arm) begin
            hold_arm = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 36);
         end
      end
   end

   // Watchdog. Any cycle in which neither channel completes a transaction counts
   // as quiet; a long enough quiet stretch means the block has hung.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout after %0d quiet cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // Sends one character transaction. It is entered and left at a falling edge.
   // Random idle cycles go in front of the transaction unless steady is set.
   task automatic send_char(input char_type c, input bit w_end, input bit s_end);
      while (!steady && ($urandom_range(0, 99) < 36)) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.character <= c;
      req_chan.word_end  <= w_end;
      req_chan.set_end   <= s_end;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      chars_sent++;
      @(negedge clock);
   endtask

   // Sends word_buf as one word. On the last word of a set, set_end goes on its
   // final character; mark_end says whether word_end goes there as well, since
   // set_end alone must also close the word.
   task automatic send_word(input bit last_word, input bit mark_end);
      int n;
      n = word_buf.size();
      for (int i = 0; i < n; i++)
         send_char(word_buf[i], (i == n - 1) && (!last_word || mark_end),
                   last_word && (i == n - 1));
      if (last_word) sets_sent++;
   endtask

   task automatic send_string(input string s, input bit last_word);
      word_buf.delete();
      for (int i = 0; i < s.len(); i++) word_buf.push_back(char_type'(s[i]));
      send_word(last_word, 1'b1);
   endtask

   // A wide set draws from every nonzero byte; a narrow one from three letters,
   // which makes accidental containment common.
   function automatic char_type pick_char(input bit wide);
      if (wide) return char_type'($urandom_range(1, 255));
      return char_type'(8'h61 + $urandom_range(0, 2));
   endfunction

   // One random set. Later words are often cut out of, copied from, or wrapped
   // around earlier ones, so that the search finds real containment.
   task automatic send_random_set();
      int  n_words;
      int  mode;
      int  src;
      int  start;
      int  len;
      bit  wide;
      hist_text.delete();
      hist_off.delete();
      hist_len.delete();
      n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 7);
      wide = ($urandom_range(0, 3) == 0);
      for (int w = 0; w < n_words; w++) begin
         word_buf.delete();
         mode = $urandom_range(0, 99);
         src = (w > 0) ? $urandom_range(0, w - 1) : 0;
         if (w > 0 && mode < 40) begin
            // Piece of an earlier word.
            start = $urandom_range(0, hist_len[src] - 1);
            len = $urandom_range(1, hist_len[src] - start);
            for (int i = 0; i < len; i++)
               word_buf.push_back(hist_text[hist_off[src] + start + i]);
         end else if (w > 0 && mode < 50) begin
            // Exact duplicate of an earlier word.
            for (int i = 0; i < hist_len[src]; i++)
               word_buf.push_back(hist_text[hist_off[src] + i]);
         end else if (w > 0 && mode < 60) begin
            // Earlier word with a few characters around it.
            repeat ($urandom_range(0, 2)) word_buf.push_back(pick_char(wide));
            for (int i = 0; i < hist_len[src]; i++)
               word_buf.push_back(hist_text[hist_off[src] + i]);
            repeat ($urandom_range(0, 2)) word_buf.push_back(pick_char(wide));
         end else begin
            repeat ($urandom_range(1, 6)) word_buf.push_back(pick_char(wide));
         end
         hist_off.push_back(hist_text.size());
         hist_len.push_back(word_buf.size());
         foreach (word_buf[i]) hist_text.push_back(word_buf[i]);
         send_word(w == n_words - 1, $urandom_range(0, 3) != 0);
      end
   endtask

   initial begin : stimulus
      int  base;
      bit  hold_done;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.character = '0;
      req_chan.word_end = 1'b0;
      req_chan.set_end = 1'b0;
      steady = 1'b0;
      hold_arm = 1'b0;
      hold_done = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sets. Extreme byte values: the lowest and highest nonzero
      // characters, each found inside a two-character word.
      word_buf = '{8'hFF, 8'h01};
      send_word(1'b0, 1'b1);
      word_buf = '{8'h01};
      send_word(1'b0, 1'b1);
      word_buf = '{8'hFF};
      send_word(1'b1, 1'b1);
      // A zero byte is stored and compared like any other character.
      word_buf = '{8'h00, 8'h41};
      send_word(1'b0, 1'b1);
      word_buf = '{8'h00};
      send_word(1'b1, 1'b1);
      // Two equal words each count, since each lies inside the other.
      send_string("q", 1'b0);
      send_string("q", 1'b1);
      // The final word is closed by set_end alone, without word_end.
      send_string("xy", 1'b0);
      word_buf = '{char_type'("y")};
      send_word(1'b1, 1'b0);
      // A set of one word can contain nothing.
      send_string("z", 1'b1);
      // Mirror words that miss each other but both sit inside a third.
      send_string("ab", 1'b0);
      send_string("ba", 1'b0);
      send_string("aba", 1'b1);

      // Overlong word: only its first MAX_LEN bytes are kept. One word equals
      // that stored prefix, another spans the cut and must not match there.
      word_buf.delete();
      repeat (LONG_WORD_LEN) word_buf.push_back(pick_char(1'b1));
      hist_text = word_buf;
      send_word(1'b0, 1'b1);
      word_buf.delete();
      for (int i = 0; i < MAX_LEN; i++) word_buf.push_back(hist_text[i]);
      send_word(1'b0, 1'b1);
      word_buf.delete();
      for (int i = MAX_LEN - 1; i < MAX_LEN + 2; i++) word_buf.push_back(hist_text[i]);
      send_word(1'b1, 1'b1);

      // Random sets. Early on the receiver is held off once while sets keep
      // coming; in the middle both sides run with no idle cycles at all.
      base = chars_sent;
      while (chars_sent - base < RANDOM_ITEMS) begin
         if (!hold_done && chars_sent - base >= 100) begin
            hold_arm = 1'b1;
            hold_done = 1'b1;
         end
         steady = (chars_sent - base >= 300) && (chars_sent - base < 450);
         send_random_set();
      end
      steady = 1'b0;
      req_chan.valid <= 1'b0;

      // Every set has one count; wait for all of them, then a little longer in
      // case a stray count follows.
      while (counts_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d characters in %0d word sets, with extreme and zero bytes,",
               chars_sent, sets_sent);
      $display("a word past %0d characters and a stalled receiver; %0d counts compared, %0d failures.",
               MAX_LEN, counts_checked, error_total);
      if (error_total == 0 && counts_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
